// File: design/b64_pkg.sv
// shared types, codes and the character classifier for the base64 stream decoder
`default_nettype none
package b64_pkg;

  // character classes
  typedef enum logic [1:0] {
    CLS_VALID = 2'd0,
    CLS_PAD   = 2'd1,
    CLS_BAD   = 2'd2
  } b64_cls_t;

  // end-of-message status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_INVALID = 2'd2
  } b64_status_t;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;
  localparam logic [2:0]  CHARS_FULL      = 3'd4;
  localparam logic [1:0]  LAST_SLOT       = 2'd3;

  // input request
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } b64_in_t;

  // result item
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } b64_out_t;

  // results caused by one input request
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            has_status;
    b64_status_t     status;
  } b64_bundle_t;

  typedef struct packed {
    b64_cls_t   cls;
    logic [5:0] sextet;
  } b64_char_t;

  // map an ASCII code to its class and sextet value
  function automatic b64_char_t b64_classify(input logic [7:0] c);
    b64_char_t r;
    r.cls    = CLS_BAD;
    r.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.cls    = CLS_VALID;
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.cls    = CLS_VALID;
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.cls    = CLS_VALID;
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.cls    = CLS_VALID;
      r.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      r.cls    = CLS_VALID;
      r.sextet = 6'd63;
    end else if (c == 8'h3D) begin
      r.cls    = CLS_PAD;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/b64_group.sv
// group gathering, checking and decoding; message state and the byte limit register
`default_nettype none
module b64_group (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire b64_pkg::b64_in_t     req,
  input  wire logic                 take,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data,
  output b64_pkg::b64_bundle_t      bundle
);
  import b64_pkg::*;

  logic [15:0]         max_bytes;
  logic [1:0]          group_position;
  logic [2:0][5:0]     held_sextets;
  b64_cls_t [2:0]      held_classes;
  logic [2:0]          chars_seen;
  logic                stopped;
  logic                error_seen;
  logic [15:0]         bytes_emitted;

  b64_char_t           ch;
  logic                grp_full;
  logic                decode;
  logic                bad;
  logic                full_form;
  logic [1:0]          want;
  logic [15:0]         room;
  logic [1:0]          nbytes;
  logic [15:0]         bytes_emitted_next;
  logic                stopped_next;
  logic                error_seen_next;
  logic [2:0]          chars_seen_next;
  logic [5:0]          s1, s2, s3;
  b64_cls_t            k1, k2, k3;

  assign cfg_ready = 1'b1;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_valid) begin
      max_bytes <= cfg_data;
    end
  end

  // classify and check the group
  always_comb begin
    ch       = b64_classify(req.char_code);
    s1       = held_sextets[0];
    s2       = held_sextets[1];
    s3       = held_sextets[2];
    k1       = held_classes[0];
    k2       = held_classes[1];
    k3       = held_classes[2];
    grp_full = (group_position == LAST_SLOT);
    decode   = grp_full && !stopped;
    bad      = (k1 != CLS_VALID) || (k2 != CLS_VALID) || (k3 == CLS_BAD) || (ch.cls == CLS_BAD);
    full_form = (k3 == CLS_VALID) && (ch.cls == CLS_VALID);
    if (bad) begin
      want = 2'd0;
    end else if (k3 == CLS_PAD && ch.cls == CLS_PAD) begin
      want = 2'd1;
    end else if (k3 == CLS_VALID && ch.cls == CLS_PAD) begin
      want = 2'd2;
    end else if (full_form) begin
      want = 2'd3;
    end else begin
      want = 2'd0;
    end
    // clip to what the limit still allows
    room = max_bytes - bytes_emitted;
    if (!decode || bytes_emitted >= max_bytes) begin
      nbytes = 2'd0;
    end else if (room >= {14'd0, want}) begin
      nbytes = want;
    end else begin
      nbytes = room[1:0];
    end
    bytes_emitted_next = bytes_emitted + {14'd0, nbytes};
    stopped_next    = stopped | (decode & (bad | !full_form | (bytes_emitted_next >= max_bytes)));
    error_seen_next = error_seen | (decode & bad);
    chars_seen_next = (chars_seen == CHARS_FULL) ? CHARS_FULL : chars_seen + 3'd1;

    bundle.nbytes     = nbytes;
    bundle.bytes[0]   = {s1, s2[5:4]};
    bundle.bytes[1]   = {s2[3:0], s3[5:2]};
    bundle.bytes[2]   = {s3[1:0], ch.sextet};
    bundle.has_status = req.end_of_message;
    if (chars_seen_next < CHARS_FULL) begin
      bundle.status = ST_SHORT;
    end else if (error_seen_next) begin
      bundle.status = ST_INVALID;
    end else begin
      bundle.status = ST_OK;
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      held_sextets   <= '0;
      held_classes   <= {CLS_VALID, CLS_VALID, CLS_VALID};
      chars_seen     <= 3'd0;
      stopped        <= 1'b0;
      error_seen     <= 1'b0;
      bytes_emitted  <= 16'd0;
    end else if (take) begin
      if (req.end_of_message) begin
        group_position <= 2'd0;
        held_sextets   <= '0;
        held_classes   <= {CLS_VALID, CLS_VALID, CLS_VALID};
        chars_seen     <= 3'd0;
        stopped        <= 1'b0;
        error_seen     <= 1'b0;
        bytes_emitted  <= 16'd0;
      end else begin
        chars_seen    <= chars_seen_next;
        stopped       <= stopped_next;
        error_seen    <= error_seen_next;
        bytes_emitted <= bytes_emitted_next;
        if (grp_full) begin
          group_position <= 2'd0;
          held_sextets   <= '0;
          held_classes   <= {CLS_VALID, CLS_VALID, CLS_VALID};
        end else begin
          group_position               <= group_position + 2'd1;
          held_sextets[group_position] <= ch.sextet;
          held_classes[group_position] <= ch.cls;
        end
      end
    end
  end

  // bytes only come out of a completed group
  a_bytes_need_group: assert property (@(posedge clk) disable iff (rst)
    (take && bundle.nbytes != 2'd0) |-> (group_position == LAST_SLOT))
    else $error("bytes produced before a group was complete");

  // end of message leaves a clean state
  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    (take && req.end_of_message) |=> (group_position == 2'd0 && chars_seen == 3'd0
                                      && !stopped && bytes_emitted == 16'd0))
    else $error("message state not cleared after end of message");

  // character count saturates at a full group
  a_chars_sat: assert property (@(posedge clk) disable iff (rst)
    chars_seen <= CHARS_FULL)
    else $error("character count beyond saturation");

endmodule
`default_nettype wire

// File: design/b64_emit.sv
// result register handing out one request's bytes and status, one per cycle while res_ready
`default_nettype none
module b64_emit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire b64_pkg::b64_bundle_t bundle,
  input  wire logic                 take,
  output logic                      free,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output b64_pkg::b64_out_t         res_data
);
  import b64_pkg::*;

  logic [2:0][7:0] bytes;
  logic [1:0]      nbytes;
  logic [1:0]      idx;
  logic            stat_pend;
  b64_status_t     status;
  logic [2:0]      remaining;
  logic            byte_phase;
  logic            pop;

  // items still to hand out
  always_comb begin
    remaining  = {1'b0, nbytes - idx} + {2'd0, stat_pend};
    byte_phase = (idx < nbytes);
    res_valid  = (remaining != 3'd0);
    pop        = res_valid && res_ready;
    free       = (remaining == 3'd0) || (remaining == 3'd1 && res_ready);
  end

  // result fields
  always_comb begin
    res_data.kind      = byte_phase ? KIND_DATA : KIND_STATUS;
    res_data.data_byte = byte_phase ? bytes[idx] : 8'd0;
    res_data.status    = byte_phase ? ST_OK : status;
    res_data.last      = !byte_phase;
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      bytes  <= bundle.bytes;
      status <= bundle.status;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      nbytes    <= 2'd0;
      idx       <= 2'd0;
      stat_pend <= 1'b0;
    end else if (take) begin
      nbytes    <= bundle.nbytes;
      idx       <= 2'd0;
      stat_pend <= bundle.has_status;
    end else if (pop) begin
      if (byte_phase) begin
        idx <= idx + 2'd1;
      end else begin
        stat_pend <= 1'b0;
      end
    end
  end

  // read position never passes the byte count
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= nbytes)
    else $error("byte index beyond byte count");

  // a loaded bundle with content is offered next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (take && (bundle.nbytes != 2'd0 || bundle.has_status)) |=> res_valid)
    else $error("loaded results not offered");

  // a request is only taken when the holding register drains
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid) |-> (remaining == 3'd1 && res_ready))
    else $error("pending results overwritten");

endmodule
`default_nettype wire

// File: design/base64_stream_decoder.sv
// top level of the base64 stream decoder
`default_nettype none
// Base64 (standard alphabet, '=' padding) decoder taking one character per request.
// The group check and decode sit between the message state and a result holding
// register, which then hands out the results of that character one per cycle while
// the result port is ready: up to three bytes when it completes a group, plus a
// status item when it ends the message. While the results of one character are handed
// out the next character is not taken until the last of them is being taken, so the
// result port sets the rate. Of a full group of four characters, the three that fill
// it make no result and the one that completes it gives up to three bytes; the closing
// character adds a status item.
// The byte limit register is written through cfg and should only change between
// messages; bytes sent before a status of invalid must be dropped by the consumer.
module base64_stream_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               char_valid,
  output logic                    char_ready,
  input  wire b64_pkg::b64_in_t   char_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output b64_pkg::b64_out_t       res_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import b64_pkg::*;

  b64_bundle_t bundle;
  logic        take;
  logic        free;

  // request accepted when the holding register can take its results
  assign char_ready = free;
  assign take       = char_valid && free;

  b64_group u_group (
    .clk       (clk),
    .rst       (rst),
    .req       (char_data),
    .take      (take),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .bundle    (bundle)
  );

  b64_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .take      (take),
    .free      (free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
`default_nettype wire
